[rtl/core/dkht_pkg.sv]
// Shared types and constants of the digest-keyed hash table.
// No dependencies; used by the top level, the sequencer and the checker.
package dkht_pkg;

    localparam int SLOT_COUNT  = 4096;
    localparam int SLOT_AW     = $clog2(SLOT_COUNT);
    localparam int PROBE_STEP  = 5;
    localparam int CHAIN_DEPTH = 128;
    localparam int CHAIN_AW    = $clog2(CHAIN_DEPTH);
    localparam int CNT_W       = $clog2(CHAIN_DEPTH + 1);
    localparam int KEY_W       = 256;
    localparam int NUM_W       = 31;
    localparam int USED_W      = 13;
    localparam int LIMIT_W     = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);
    localparam logic [USED_W-1:0]  USED_HALF   = USED_W'(SLOT_COUNT / 2 - 1);

    localparam logic [1:0] KIND_FIND   = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    typedef enum logic [2:0] {
        ST_FOUND      = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_INSERTED   = 3'd2,
        ST_DELETED    = 3'd3,
        ST_FULL       = 3'd4,
        ST_CHAIN_LONG = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PR_FOUND,
        PR_EMPTY,
        PR_NONE
    } probe_res_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_ACT,
        S_COUNT,
        S_CLR_DEL,
        S_LIFT,
        S_RE_RD,
        S_RE_LD,
        S_RE_PROBE,
        S_DEL_END,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] entry_number;
        logic [11:0] slot_index;
    } out_word_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [KEY_W-1:0] key;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

[rtl/core/digest_keyed_hash_table.sv]
// Top level of the digest-keyed hash table: sequencer, slot store, chain buffer.
// Depends on dkht_pkg, dkht_ram and dkht_ctrl.
//
// Usage: a word on s_data (kind, four key words) is taken when s_valid and
// s_ready are high; each word yields exactly one result word on m_data
// (status, entry number, slot), handed over when m_valid and m_ready are high.
// cfg_wr_en writes the delete chain limit from cfg_wr_data in the same cycle.
// Operation: the probe loop reads one slot per cycle from the slot RAM; a
// find or insert then passes the action state and the done state, which
// hands the result to the output register. A delete that finds its key then
// measures the chain behind the deleted slot, empties that slot, lifts the
// chain into the chain buffer, re-inserts each lifted entry from its home
// slot and closes. One word is worked on at a time; the next is taken once
// the previous result sits in the output register. After reset a clearing
// pass empties all 4096 slots, one a cycle, with s_ready low. When the
// receiver stalls, the result word is held and a finished following result
// waits in the sequencer until it drains.
module digest_keyed_hash_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  dkht_pkg::in_word_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output dkht_pkg::out_word_t          m_data,
    input  logic                         cfg_wr_en,
    input  logic [dkht_pkg::LIMIT_W-1:0] cfg_wr_data
);

    logic                          slot_we;
    logic [dkht_pkg::SLOT_AW-1:0]  slot_wr_addr;
    logic [dkht_pkg::ENTRY_W-1:0]  slot_wr_data;
    logic [dkht_pkg::SLOT_AW-1:0]  slot_rd_addr;
    logic [dkht_pkg::ENTRY_W-1:0]  slot_rd_data;
    logic                          chain_we;
    logic [dkht_pkg::CHAIN_AW-1:0] chain_wr_addr;
    logic [dkht_pkg::ENTRY_W-1:0]  chain_wr_data;
    logic [dkht_pkg::CHAIN_AW-1:0] chain_rd_addr;
    logic [dkht_pkg::ENTRY_W-1:0]  chain_rd_data;

    // sequencer
    dkht_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .slot_we       (slot_we),
        .slot_wr_addr  (slot_wr_addr),
        .slot_wr_data  (slot_wr_data),
        .slot_rd_addr  (slot_rd_addr),
        .slot_rd_data  (slot_rd_data),
        .chain_we      (chain_we),
        .chain_wr_addr (chain_wr_addr),
        .chain_wr_data (chain_wr_data),
        .chain_rd_addr (chain_rd_addr),
        .chain_rd_data (chain_rd_data)
    );

    // slot store: number and key per slot
    dkht_ram #(
        .DEPTH (dkht_pkg::SLOT_COUNT),
        .WIDTH (dkht_pkg::ENTRY_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .we      (slot_we),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    // chain buffer for delete
    dkht_ram #(
        .DEPTH (dkht_pkg::CHAIN_DEPTH),
        .WIDTH (dkht_pkg::ENTRY_W)
    ) u_chain_ram (
        .aclk    (aclk),
        .we      (chain_we),
        .wr_addr (chain_wr_addr),
        .wr_data (chain_wr_data),
        .rd_addr (chain_rd_addr),
        .rd_data (chain_rd_data)
    );

endmodule

[rtl/core/dkht_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies; holds the slot store and the chain buffer.
module dkht_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/dkht_ctrl.sv]
// Sequencer of the hash table: probing, insert, delete with chain re-insert.
// Depends on dkht_pkg; drives the slot RAM and the chain buffer RAM.
module dkht_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  dkht_pkg::in_word_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output dkht_pkg::out_word_t               m_data,
    input  logic                              cfg_wr_en,
    input  logic [dkht_pkg::LIMIT_W-1:0]      cfg_wr_data,
    output logic                              slot_we,
    output logic [dkht_pkg::SLOT_AW-1:0]      slot_wr_addr,
    output logic [dkht_pkg::ENTRY_W-1:0]      slot_wr_data,
    output logic [dkht_pkg::SLOT_AW-1:0]      slot_rd_addr,
    input  logic [dkht_pkg::ENTRY_W-1:0]      slot_rd_data,
    output logic                              chain_we,
    output logic [dkht_pkg::CHAIN_AW-1:0]     chain_wr_addr,
    output logic [dkht_pkg::ENTRY_W-1:0]      chain_wr_data,
    output logic [dkht_pkg::CHAIN_AW-1:0]     chain_rd_addr,
    input  logic [dkht_pkg::ENTRY_W-1:0]      chain_rd_data
);

    localparam logic [dkht_pkg::SLOT_AW-1:0] STEP     = dkht_pkg::SLOT_AW'(dkht_pkg::PROBE_STEP);
    localparam logic [dkht_pkg::SLOT_AW-1:0] LAST_SLT = dkht_pkg::SLOT_AW'(dkht_pkg::SLOT_COUNT - 1);
    localparam logic [dkht_pkg::LIMIT_W-1:0] DEPTH_L  = dkht_pkg::LIMIT_W'(dkht_pkg::CHAIN_DEPTH);

    dkht_pkg::state_t                 state_reg, state_next;
    dkht_pkg::probe_res_t             pres_reg, pres_next;
    logic [1:0]                       kind_reg, kind_next;
    logic [dkht_pkg::KEY_W-1:0]       pk_reg, pk_next;
    logic [dkht_pkg::NUM_W-1:0]       pnum_reg, pnum_next;
    logic [dkht_pkg::NUM_W-1:0]       hit_reg, hit_next;
    logic [dkht_pkg::SLOT_AW-1:0]     cur_reg, cur_next;
    logic [dkht_pkg::SLOT_AW-1:0]     del_reg, del_next;
    logic [dkht_pkg::SLOT_AW-1:0]     n_reg, n_next;
    logic [dkht_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [dkht_pkg::CNT_W-1:0]       k_reg, k_next;
    logic [dkht_pkg::USED_W-1:0]      used_reg, used_next;
    logic [dkht_pkg::NUM_W-1:0]       serial_reg, serial_next;
    logic [dkht_pkg::LIMIT_W-1:0]     limit_reg;
    dkht_pkg::out_word_t              res_reg, res_next;
    logic                             out_valid_reg, out_valid_next;
    dkht_pkg::out_word_t              out_reg, out_next;

    dkht_pkg::slot_entry_t            rd_ent;
    dkht_pkg::slot_entry_t            ch_ent;
    dkht_pkg::slot_entry_t            wr_ent;
    dkht_pkg::slot_entry_t            cw_ent;
    logic                             occ;
    logic                             key_eq;
    logic [dkht_pkg::LIMIT_W-1:0]     lim;
    logic [dkht_pkg::CNT_W:0]         cnt_inc;
    logic [dkht_pkg::CNT_W-1:0]       k_inc;
    logic [dkht_pkg::SLOT_AW-1:0]     cur_step;

    assign rd_ent   = dkht_pkg::slot_entry_t'(slot_rd_data);
    assign ch_ent   = dkht_pkg::slot_entry_t'(chain_rd_data);
    assign occ      = (rd_ent.num != '0);
    assign key_eq   = (rd_ent.key == pk_reg);
    assign lim      = (limit_reg > DEPTH_L) ? DEPTH_L : limit_reg;
    assign cnt_inc  = {1'b0, cnt_reg} + (dkht_pkg::CNT_W+1)'(1);
    assign k_inc    = k_reg + dkht_pkg::CNT_W'(1);
    assign cur_step = cur_reg + STEP;

    assign slot_wr_data  = wr_ent;
    assign chain_wr_data = cw_ent;
    assign s_ready       = (state_reg == dkht_pkg::S_IDLE);
    assign m_valid       = out_valid_reg;
    assign m_data        = out_reg;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= dkht_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dkht_pkg::S_CLEAR;
            cur_reg       <= '0;
            used_reg      <= '0;
            serial_reg    <= dkht_pkg::NUM_W'(1);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            used_reg      <= used_next;
            serial_reg    <= serial_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        pres_reg <= pres_next;
        kind_reg <= kind_next;
        pk_reg   <= pk_next;
        pnum_reg <= pnum_next;
        hit_reg  <= hit_next;
        del_reg  <= del_next;
        n_reg    <= n_next;
        cnt_reg  <= cnt_next;
        k_reg    <= k_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        pres_next      = pres_reg;
        kind_next      = kind_reg;
        pk_next        = pk_reg;
        pnum_next      = pnum_reg;
        hit_next       = hit_reg;
        cur_next       = cur_reg;
        del_next       = del_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        used_next      = used_reg;
        serial_next    = serial_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        slot_we        = 1'b0;
        slot_wr_addr   = cur_reg;
        wr_ent         = '{num: '0, key: pk_reg};
        slot_rd_addr   = cur_reg;
        chain_we       = 1'b0;
        chain_wr_addr  = k_reg[dkht_pkg::CHAIN_AW-1:0];
        cw_ent         = rd_ent;
        chain_rd_addr  = k_reg[dkht_pkg::CHAIN_AW-1:0];

        // drop the result word once taken
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            // empty every slot after reset
            dkht_pkg::S_CLEAR: begin
                slot_we  = 1'b1;
                cur_next = cur_step - STEP + dkht_pkg::SLOT_AW'(1);
                if (cur_reg == LAST_SLT) begin
                    state_next = dkht_pkg::S_IDLE;
                end
            end
            dkht_pkg::S_IDLE: begin
                slot_rd_addr = s_data.key_word0[dkht_pkg::SLOT_AW-1:0];
                if (s_valid) begin
                    kind_next  = s_data.kind;
                    pk_next    = {s_data.key_word3, s_data.key_word2,
                                  s_data.key_word1, s_data.key_word0};
                    cur_next   = s_data.key_word0[dkht_pkg::SLOT_AW-1:0];
                    n_next     = '0;
                    state_next = dkht_pkg::S_PROBE;
                end
            end
            // one slot examined per cycle
            dkht_pkg::S_PROBE: begin
                hit_next = rd_ent.num;
                if (!occ) begin
                    pres_next  = dkht_pkg::PR_EMPTY;
                    state_next = dkht_pkg::S_ACT;
                end else if (key_eq) begin
                    pres_next  = dkht_pkg::PR_FOUND;
                    state_next = dkht_pkg::S_ACT;
                end else if (n_reg == LAST_SLT) begin
                    pres_next  = dkht_pkg::PR_NONE;
                    state_next = dkht_pkg::S_ACT;
                end else begin
                    cur_next     = cur_step;
                    slot_rd_addr = cur_step;
                    n_next       = n_reg + dkht_pkg::SLOT_AW'(1);
                end
            end
            dkht_pkg::S_ACT: begin
                state_next = dkht_pkg::S_DONE;
                res_next   = '{status: dkht_pkg::ST_NOT_FOUND, entry_number: '0,
                               slot_index: '0};
                if (kind_reg == dkht_pkg::KIND_INSERT) begin
                    if (pres_reg == dkht_pkg::PR_FOUND) begin
                        res_next = '{status: dkht_pkg::ST_FOUND, entry_number: hit_reg,
                                     slot_index: cur_reg};
                    end else if (pres_reg == dkht_pkg::PR_NONE || serial_reg == '0 ||
                                 used_reg >= dkht_pkg::USED_HALF) begin
                        res_next.status = dkht_pkg::ST_FULL;
                    end else begin
                        slot_we     = 1'b1;
                        wr_ent      = '{num: serial_reg, key: pk_reg};
                        used_next   = used_reg + dkht_pkg::USED_W'(1);
                        serial_next = serial_reg + dkht_pkg::NUM_W'(1);
                        res_next    = '{status: dkht_pkg::ST_INSERTED,
                                        entry_number: serial_reg, slot_index: cur_reg};
                    end
                end else if (kind_reg == dkht_pkg::KIND_DELETE) begin
                    if (pres_reg == dkht_pkg::PR_FOUND) begin
                        del_next     = cur_reg;
                        cur_next     = cur_step;
                        slot_rd_addr = cur_step;
                        cnt_next     = '0;
                        state_next   = dkht_pkg::S_COUNT;
                    end
                end else if (pres_reg == dkht_pkg::PR_FOUND) begin
                    res_next = '{status: dkht_pkg::ST_FOUND, entry_number: hit_reg,
                                 slot_index: cur_reg};
                end
            end
            // measure the chain behind the deleted slot
            dkht_pkg::S_COUNT: begin
                if (cur_reg == del_reg || !occ) begin
                    cur_next   = del_reg + STEP;
                    state_next = dkht_pkg::S_CLR_DEL;
                end else if (cnt_inc > {1'b0, lim}) begin
                    res_next   = '{status: dkht_pkg::ST_CHAIN_LONG, entry_number: '0,
                                   slot_index: '0};
                    state_next = dkht_pkg::S_DONE;
                end else begin
                    cnt_next     = cnt_inc[dkht_pkg::CNT_W-1:0];
                    cur_next     = cur_step;
                    slot_rd_addr = cur_step;
                end
            end
            // empty the deleted slot, fetch the first chained entry
            dkht_pkg::S_CLR_DEL: begin
                slot_we      = 1'b1;
                slot_wr_addr = del_reg;
                k_next       = '0;
                state_next   = (cnt_reg == '0) ? dkht_pkg::S_DEL_END : dkht_pkg::S_LIFT;
            end
            // move one chained entry a cycle into the buffer
            dkht_pkg::S_LIFT: begin
                chain_we = 1'b1;
                slot_we  = 1'b1;
                if (k_inc == cnt_reg) begin
                    k_next     = '0;
                    state_next = dkht_pkg::S_RE_RD;
                end else begin
                    k_next       = k_inc;
                    cur_next     = cur_step;
                    slot_rd_addr = cur_step;
                end
            end
            dkht_pkg::S_RE_RD: begin
                state_next = dkht_pkg::S_RE_LD;
            end
            dkht_pkg::S_RE_LD: begin
                pk_next      = ch_ent.key;
                pnum_next    = ch_ent.num;
                cur_next     = ch_ent.key[dkht_pkg::SLOT_AW-1:0];
                slot_rd_addr = ch_ent.key[dkht_pkg::SLOT_AW-1:0];
                n_next       = '0;
                state_next   = dkht_pkg::S_RE_PROBE;
            end
            // place a lifted entry at the first empty slot from its home
            dkht_pkg::S_RE_PROBE: begin
                if (!occ || n_reg == LAST_SLT) begin
                    if (!occ) begin
                        slot_we = 1'b1;
                        wr_ent  = '{num: pnum_reg, key: pk_reg};
                    end
                    k_next     = k_inc;
                    state_next = (k_inc == cnt_reg) ? dkht_pkg::S_DEL_END
                                                    : dkht_pkg::S_RE_RD;
                end else begin
                    cur_next     = cur_step;
                    slot_rd_addr = cur_step;
                    n_next       = n_reg + dkht_pkg::SLOT_AW'(1);
                end
            end
            dkht_pkg::S_DEL_END: begin
                if (used_reg != '0) begin
                    used_next = used_reg - dkht_pkg::USED_W'(1);
                end
                res_next   = '{status: dkht_pkg::ST_DELETED, entry_number: hit_reg,
                               slot_index: del_reg};
                state_next = dkht_pkg::S_DONE;
            end
            // hand the result to the output register when it is free
            dkht_pkg::S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = dkht_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = dkht_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/dkht_checker.sv]
// Port-level checks of the hash table, bound to the top level.
// Depends on dkht_pkg and digest_keyed_hash_table.
module dkht_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input dkht_pkg::out_word_t m_data
);

    // one word at a time: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in work");

    // hold a stalled result word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed under stall");

    // refusals and misses carry no number and no slot
    a_zero_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == dkht_pkg::ST_NOT_FOUND ||
                    m_data.status == dkht_pkg::ST_FULL ||
                    m_data.status == dkht_pkg::ST_CHAIN_LONG)
        |-> m_data.entry_number == '0 && m_data.slot_index == '0)
        else $error("miss or refusal with number or slot");

    // hits, inserts and deletes name a stored number
    a_number_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == dkht_pkg::ST_FOUND ||
                    m_data.status == dkht_pkg::ST_INSERTED ||
                    m_data.status == dkht_pkg::ST_DELETED)
        |-> m_data.entry_number != '0)
        else $error("hit without a serial number");

endmodule

bind digest_keyed_hash_table dkht_checker u_dkht_checker (.*);

[bench/tb_top.sv]
// Self-checking bench for the digest-keyed hash table: directed table, a chain-limit case, then random traffic.
// Depends on dkht_pkg and digest_keyed_hash_table; results checked against a local table model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCH_LIMIT = 200000;
    // kind code with no operation of its own, handled as a find
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    dkht_pkg::in_word_t           s_data;
    logic                         m_valid;
    logic                         m_ready;
    dkht_pkg::out_word_t          m_data;
    logic                         cfg_wr_en;
    logic [dkht_pkg::LIMIT_W-1:0] cfg_wr_data;

    digest_keyed_hash_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // table model state
    logic [dkht_pkg::KEY_W-1:0] tbl_key [dkht_pkg::SLOT_COUNT];
    logic [dkht_pkg::NUM_W-1:0] tbl_num [dkht_pkg::SLOT_COUNT];
    int unsigned                tbl_used;
    logic [dkht_pkg::NUM_W-1:0] tbl_next;
    int unsigned                tbl_limit;

    dkht_pkg::out_word_t result_fifo[$];
    int        err_count;
    int        words_sent;
    int        words_seen;
    int        idle_cycles;
    bit        long_hold;
    int        n_found, n_inserted, n_deleted, n_full, n_long;

    logic [63:0] key_pool [64];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [dkht_pkg::SLOT_AW-1:0] step_slot(
        logic [dkht_pkg::SLOT_AW-1:0] s);
        return dkht_pkg::SLOT_AW'((int'(s) + dkht_pkg::PROBE_STEP) % dkht_pkg::SLOT_COUNT);
    endfunction

    // walk from home slot: 0 key found, 1 empty slot, 2 none
    function automatic int walk_probe(logic [dkht_pkg::KEY_W-1:0] k, bit match,
                                      output logic [dkht_pkg::SLOT_AW-1:0] at);
        logic [dkht_pkg::SLOT_AW-1:0] s;
        s  = k[dkht_pkg::SLOT_AW-1:0];
        at = '0;
        for (int n = 0; n < dkht_pkg::SLOT_COUNT; n++) begin
            if (tbl_num[s] == 0) begin
                at = s;
                return 1;
            end
            if (match && tbl_key[s] == k) begin
                at = s;
                return 0;
            end
            s = step_slot(s);
        end
        return 2;
    endfunction

    // compute the result of one word and update the table
    function automatic dkht_pkg::out_word_t table_apply(dkht_pkg::in_word_t w);
        dkht_pkg::out_word_t          r;
        logic [dkht_pkg::KEY_W-1:0]   k;
        logic [dkht_pkg::SLOT_AW-1:0] at, j, dst;
        logic [dkht_pkg::KEY_W-1:0]   lift_key [$];
        logic [dkht_pkg::NUM_W-1:0]   lift_num [$];
        logic [dkht_pkg::NUM_W-1:0]   gone;
        int                           pr, cnt, lim;
        k  = {w.key_word3, w.key_word2, w.key_word1, w.key_word0};
        pr = walk_probe(k, 1'b1, at);
        r  = '0;
        if (w.kind == dkht_pkg::KIND_INSERT) begin
            if (pr == 0) begin
                r.status = dkht_pkg::ST_FOUND; r.entry_number = tbl_num[at];
                r.slot_index = at;
            end else if (pr == 2 || tbl_next == 0 ||
                         (tbl_used + 1) * 2 >= dkht_pkg::SLOT_COUNT) begin
                r.status = dkht_pkg::ST_FULL;
            end else begin
                tbl_key[at] = k;
                tbl_num[at] = tbl_next;
                tbl_used++;
                r.status = dkht_pkg::ST_INSERTED; r.entry_number = tbl_next;
                r.slot_index = at;
                tbl_next = tbl_next + 1'b1;
            end
            return r;
        end
        if (w.kind != dkht_pkg::KIND_DELETE) begin
            if (pr == 0) begin
                r.status = dkht_pkg::ST_FOUND; r.entry_number = tbl_num[at];
                r.slot_index = at;
            end else
                r.status = dkht_pkg::ST_NOT_FOUND;
            return r;
        end
        if (pr != 0) begin
            r.status = dkht_pkg::ST_NOT_FOUND;
            return r;
        end
        lim = (tbl_limit > dkht_pkg::CHAIN_DEPTH) ? dkht_pkg::CHAIN_DEPTH : tbl_limit;
        cnt = 0;
        j   = step_slot(at);
        while (j != at && tbl_num[j] != 0) begin
            cnt++;
            if (cnt > lim) begin
                r.status = dkht_pkg::ST_CHAIN_LONG;
                return r;
            end
            j = step_slot(j);
        end
        gone        = tbl_num[at];
        tbl_num[at] = '0;
        j           = step_slot(at);
        // lift the chain out, then re-insert from home slots
        for (int i = 0; i < cnt; i++) begin
            lift_key.push_back(tbl_key[j]);
            lift_num.push_back(tbl_num[j]);
            tbl_num[j] = '0;
            j = step_slot(j);
        end
        for (int i = 0; i < cnt; i++) begin
            if (walk_probe(lift_key[i], 1'b0, dst) == 1) begin
                tbl_key[dst] = lift_key[i];
                tbl_num[dst] = lift_num[i];
            end
        end
        if (tbl_used > 0) tbl_used--;
        r.status = dkht_pkg::ST_DELETED; r.entry_number = gone; r.slot_index = at;
        return r;
    endfunction

    task automatic report_mismatch(string what, dkht_pkg::out_word_t got,
                                   dkht_pkg::out_word_t want);
        $display("mismatch %s: got st=%0d num=%0d slot=%0d, want st=%0d num=%0d slot=%0d",
                 what, got.status, got.entry_number, got.slot_index,
                 want.status, want.entry_number, want.slot_index);
        err_count++;
    endtask

    // check result words against the oldest expectation
    always @(posedge aclk) begin
        dkht_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (result_fifo.size() == 0)
                report_mismatch("unexpected word", m_data, '0);
            else begin
                want = result_fifo.pop_front();
                if (m_data.status !== want.status || m_data.entry_number !== want.entry_number
                    || m_data.slot_index !== want.slot_index)
                    report_mismatch("field", m_data, want);
                case (want.status)
                    dkht_pkg::ST_FOUND:      n_found++;
                    dkht_pkg::ST_INSERTED:   n_inserted++;
                    dkht_pkg::ST_DELETED:    n_deleted++;
                    dkht_pkg::ST_FULL:       n_full++;
                    dkht_pkg::ST_CHAIN_LONG: n_long++;
                    default: ;
                endcase
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int cyc;
        int hold;
        m_ready = 1'b0;
        cyc     = 0;
        hold    = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (long_hold && hold == 0) hold = 400;
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
                if (hold == 0) long_hold = 1'b0;
            end else if ((cyc / 300) % 3 == 0)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog on accept activity
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else if (++idle_cycles >= WATCH_LIMIT) begin
                $display("watchdog expired: sent %0d, seen %0d", words_sent, words_seen);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // drive one word and hold until accepted
    task automatic send_word(logic [1:0] kind, logic [63:0] w0, logic [63:0] w1,
                             logic [63:0] w2, logic [63:0] w3, bit typed,
                             dkht_pkg::out_word_t want);
        dkht_pkg::in_word_t  w;
        dkht_pkg::out_word_t got;
        w = '{kind: kind, key_word0: w0, key_word1: w1, key_word2: w2, key_word3: w3};
        got = table_apply(w);
        if (typed && got != want)
            report_mismatch("directed row vs model", got, want);
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        result_fifo.push_back(got);
        words_sent++;
    endtask

    task automatic pause_word(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (result_fifo.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_limit(int v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dkht_pkg::LIMIT_W'(v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tbl_limit    = v;
        @(posedge aclk);
    endtask

    // random key drawn from a small pool, many sharing home slots
    function automatic logic [63:0] pool_word0();
        logic [63:0] x;
        x = key_pool[$urandom_range(0, 63)];
        if ($urandom_range(0, 3) == 0)
            x = {$urandom, $urandom};
        return x;
    endfunction

    typedef struct {
        logic [1:0]          kind;
        logic [63:0]         w0, w1, w2, w3;
        bit                  typed;
        dkht_pkg::out_word_t want;
    } row_t;

    row_t rows [$];
    int   burst;

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        long_hold   = 1'b0;
        err_count   = 0;
        words_sent  = 0;
        words_seen  = 0;
        for (int i = 0; i < dkht_pkg::SLOT_COUNT; i++) begin
            tbl_num[i] = '0;
            tbl_key[i] = '0;
        end
        tbl_used  = 0;
        tbl_next  = 1;
        tbl_limit = 100;
        for (int i = 0; i < 64; i++)
            key_pool[i] = {$urandom, 20'h0, 12'($urandom_range(0, 40))};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table: extremes, every kind, chain cases, unused kind
        rows.push_back('{dkht_pkg::KIND_FIND, 64'h0, 64'h0, 64'h0, 64'h0, 1,
                         '{dkht_pkg::ST_NOT_FOUND, 0, 0}});
        rows.push_back('{dkht_pkg::KIND_DELETE, 64'h0, 64'h0, 64'h0, 64'h0, 1,
                         '{dkht_pkg::ST_NOT_FOUND, 0, 0}});
        rows.push_back('{dkht_pkg::KIND_INSERT, 64'h0, 64'h0, 64'h0, 64'h0, 1,
                         '{dkht_pkg::ST_INSERTED, 1, 0}});
        rows.push_back('{dkht_pkg::KIND_INSERT, 64'h0, 64'h0, 64'h0, 64'h0, 1,
                         '{dkht_pkg::ST_FOUND, 1, 0}});
        rows.push_back('{dkht_pkg::KIND_INSERT, '1, '1, '1, '1, 1,
                         '{dkht_pkg::ST_INSERTED, 2, 12'hFFF}});
        rows.push_back('{dkht_pkg::KIND_INSERT, 64'h0, 64'h0, 64'h0, 64'h1, 1,
                         '{dkht_pkg::ST_INSERTED, 3, 5}});
        rows.push_back('{dkht_pkg::KIND_INSERT, 64'h1000, '1, 64'h0, '1, 1,
                         '{dkht_pkg::ST_INSERTED, 4, 10}});
        rows.push_back('{KIND_SPARE, '1, '1, '1, '1, 1,
                         '{dkht_pkg::ST_FOUND, 2, 12'hFFF}});
        rows.push_back('{dkht_pkg::KIND_FIND, 64'h0, 64'h0, 64'h0, 64'h1, 1,
                         '{dkht_pkg::ST_FOUND, 3, 5}});
        rows.push_back('{dkht_pkg::KIND_FIND, '1, '1, '1, 64'h0, 1,
                         '{dkht_pkg::ST_NOT_FOUND, 0, 0}});
        rows.push_back('{dkht_pkg::KIND_DELETE, 64'h0, 64'h0, 64'h0, 64'h0, 1,
                         '{dkht_pkg::ST_DELETED, 1, 0}});
        rows.push_back('{dkht_pkg::KIND_FIND, 64'h0, 64'h0, 64'h0, 64'h1, 0,
                         '{dkht_pkg::ST_FOUND, 3, 0}});
        rows.push_back('{dkht_pkg::KIND_FIND, 64'h1000, '1, 64'h0, '1, 0, '0});
        rows.push_back('{dkht_pkg::KIND_DELETE, 64'h0, 64'h0, 64'h0, 64'h1, 0, '0});
        rows.push_back('{dkht_pkg::KIND_DELETE, '1, '1, '1, '1, 1,
                         '{dkht_pkg::ST_DELETED, 2, 12'hFFF}});
        foreach (rows[i])
            send_word(rows[i].kind, rows[i].w0, rows[i].w1, rows[i].w2, rows[i].w3,
                      rows[i].typed, rows[i].want);
        drain_results();

        // limit 0: any chain refuses the delete
        write_limit(0);
        send_word(dkht_pkg::KIND_INSERT, 64'h0, 64'h7, 64'h0, 64'h0, 0, '0);
        send_word(dkht_pkg::KIND_INSERT, 64'h0, 64'h8, 64'h0, 64'h0, 0, '0);
        send_word(dkht_pkg::KIND_DELETE, 64'h0, 64'h7, 64'h0, 64'h0, 1,
                  '{dkht_pkg::ST_CHAIN_LONG, 0, 0});
        drain_results();
        write_limit(255);

        // random traffic in phases with different limits
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 1) write_limit(1);
            if (ph == 2) write_limit(128);
            if (ph == 3) write_limit(3);
            for (int i = 0; i < 120; i++) begin
                logic [1:0] k;
                int r;
                r = $urandom_range(0, 9);
                k = (r < 4) ? dkht_pkg::KIND_INSERT : (r < 7) ? dkht_pkg::KIND_FIND :
                    (r < 9) ? dkht_pkg::KIND_DELETE : KIND_SPARE;
                if (i == 30 && ph == 0) long_hold = 1'b1;
                send_word(k, pool_word0(), {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, 0, '0);
                if (--burst <= 0) begin
                    burst = $urandom_range(1, 12);
                    if (ph != 0) pause_word($urandom_range(1, 6));
                end
            end
            drain_results();
        end
        write_limit(100);

        $display("sent %0d words, %0d results: found %0d, inserted %0d, deleted %0d",
                 words_sent, words_seen, n_found, n_inserted, n_deleted);
        $display("refusals: table full %0d, chain too long %0d", n_full, n_long);
        if (err_count == 0 && result_fifo.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
